// ===== src/clsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsc_pkg
// Shared constants, codes and types of the config line syntax checker.
// ----------------------------------------------------------------------------
package clsc_pkg;

	localparam int IDENT_BUFFER = 50;
	localparam int ARG_BUFFER   = 480;
	localparam int MAX_BUFFER   = (IDENT_BUFFER > ARG_BUFFER) ? IDENT_BUFFER : ARG_BUFFER;
	localparam int LEN_W        = $clog2(MAX_BUFFER);

	localparam int PHASE_W = 4;
	localparam int STATUS_W = 4;
	localparam int TAG_W = 2;

	// parse phases
	localparam logic [PHASE_W-1:0] PH_START      = 4'd0;
	localparam logic [PHASE_W-1:0] PH_IDENT      = 4'd1;
	localparam logic [PHASE_W-1:0] PH_AFTER_ID   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_AFTER_EQ   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_ARG        = 4'd4;
	localparam logic [PHASE_W-1:0] PH_AFTER_ARG  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_AFTER_SEMI = 4'd6;
	localparam logic [PHASE_W-1:0] PH_COMMENT    = 4'd7;
	localparam logic [PHASE_W-1:0] PH_ERROR      = 4'd8;

	// line status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 4'd0;
	localparam logic [STATUS_W-1:0] ST_LEADING  = 4'd1;
	localparam logic [STATUS_W-1:0] ST_ID_LONG  = 4'd2;
	localparam logic [STATUS_W-1:0] ST_NO_EQ    = 4'd3;
	localparam logic [STATUS_W-1:0] ST_NO_QUOTE = 4'd4;
	localparam logic [STATUS_W-1:0] ST_ARG_LONG = 4'd5;
	localparam logic [STATUS_W-1:0] ST_UNTERM   = 4'd6;
	localparam logic [STATUS_W-1:0] ST_NO_SEMI  = 4'd7;
	localparam logic [STATUS_W-1:0] ST_TRAILING = 4'd8;

	// result tags
	localparam logic [TAG_W-1:0] TAG_IDENT  = 2'd0;
	localparam logic [TAG_W-1:0] TAG_ARG    = 2'd1;
	localparam logic [TAG_W-1:0] TAG_STATUS = 2'd2;

	// input kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_UNDER = 8'h5f;

	typedef struct packed {
		logic is_ident;
		logic is_blank;
		logic is_eq;
		logic is_quote;
		logic is_semi;
		logic is_hash;
	} char_class_t;

	typedef struct packed {
		logic                valid;
		logic [TAG_W-1:0]    tag;
		logic [7:0]          data;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ===== src/clsc_char_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsc_char_class
// Sorts one line character into the classes the parser looks at.
// ----------------------------------------------------------------------------
module clsc_char_class import clsc_pkg::*; (
	input  logic [7:0]  char_byte,
	output char_class_t cls
);

	always_comb begin
		cls.is_ident = (char_byte >= 8'h61 && char_byte <= 8'h7a) ||
		               (char_byte >= 8'h41 && char_byte <= 8'h5a) ||
		               (char_byte >= 8'h30 && char_byte <= 8'h39) ||
		               (char_byte == CH_UNDER);
		// space, tab, lf, vt, ff, cr
		cls.is_blank = (char_byte == 8'h20) || (char_byte >= 8'h09 && char_byte <= 8'h0d);
		cls.is_eq    = (char_byte == CH_EQ);
		cls.is_quote = (char_byte == CH_QUOTE);
		cls.is_semi  = (char_byte == CH_SEMI);
		cls.is_hash  = (char_byte == CH_HASH);
	end

endmodule

// ===== src/clsc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsc_parser
// Line phase, first error and length counter, with the result of one word.
// ----------------------------------------------------------------------------
module clsc_parser import clsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        kind,
	input  logic [7:0]  char_byte,
	input  char_class_t cls,
	output result_t     res
);

	localparam logic [LEN_W:0] ID_LIMIT  = (LEN_W+1)'(IDENT_BUFFER - 1);
	localparam logic [LEN_W:0] ARG_LIMIT = (LEN_W+1)'(ARG_BUFFER - 1);
	localparam logic [LEN_W:0] ONE       = (LEN_W+1)'(1);

	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic [STATUS_W-1:0] err_q, err_d;
	logic [LEN_W-1:0]    count_q, count_d;
	logic [LEN_W:0]      cnt_inc;

	assign cnt_inc = {1'b0, count_q} + ONE;

	always_comb begin
		phase_d    = phase_q;
		err_d      = err_q;
		count_d    = count_q;
		res.valid  = 1'b0;
		res.tag    = TAG_IDENT;
		res.data   = 8'd0;
		res.status = ST_OK;

		if (kind == KIND_EOL) begin
			res.valid = 1'b1;
			res.tag   = TAG_STATUS;
			case (phase_q)
				PH_START:                 res.status = ST_LEADING;
				PH_IDENT, PH_AFTER_ID:    res.status = ST_NO_EQ;
				PH_AFTER_EQ:              res.status = ST_NO_QUOTE;
				PH_ARG:                   res.status = ST_UNTERM;
				PH_AFTER_ARG:             res.status = ST_NO_SEMI;
				PH_AFTER_SEMI, PH_COMMENT: res.status = ST_OK;
				default:                  res.status = err_q;
			endcase
			phase_d = PH_START;
			err_d   = ST_OK;
			count_d = '0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (!cls.is_ident) begin
						phase_d = PH_ERROR;
						err_d   = ST_LEADING;
					end else if (ONE >= ID_LIMIT) begin
						phase_d = PH_ERROR;
						err_d   = ST_ID_LONG;
						count_d = LEN_W'(1);
					end else begin
						phase_d   = PH_IDENT;
						count_d   = LEN_W'(1);
						res.valid = 1'b1;
						res.data  = char_byte;
					end
				end
				PH_IDENT: begin
					if (cls.is_ident) begin
						count_d = cnt_inc[LEN_W-1:0];
						if (cnt_inc >= ID_LIMIT) begin
							phase_d = PH_ERROR;
							err_d   = ST_ID_LONG;
						end else begin
							res.valid = 1'b1;
							res.data  = char_byte;
						end
					end else if (cls.is_eq) begin
						phase_d = PH_AFTER_EQ;
					end else if (cls.is_blank) begin
						phase_d = PH_AFTER_ID;
					end else begin
						phase_d = PH_ERROR;
						err_d   = ST_NO_EQ;
					end
				end
				PH_AFTER_ID: begin
					if (cls.is_eq) begin
						phase_d = PH_AFTER_EQ;
					end else if (!cls.is_blank) begin
						phase_d = PH_ERROR;
						err_d   = ST_NO_EQ;
					end
				end
				PH_AFTER_EQ: begin
					if (cls.is_quote) begin
						phase_d = PH_ARG;
						count_d = '0;
					end else if (!cls.is_blank) begin
						phase_d = PH_ERROR;
						err_d   = ST_NO_QUOTE;
					end
				end
				PH_ARG: begin
					if (cls.is_quote) begin
						phase_d = PH_AFTER_ARG;
					end else begin
						count_d = cnt_inc[LEN_W-1:0];
						if (cnt_inc >= ARG_LIMIT) begin
							phase_d = PH_ERROR;
							err_d   = ST_ARG_LONG;
						end else begin
							res.valid = 1'b1;
							res.tag   = TAG_ARG;
							res.data  = char_byte;
						end
					end
				end
				PH_AFTER_ARG: begin
					if (cls.is_semi) begin
						phase_d = PH_AFTER_SEMI;
					end else if (!cls.is_blank) begin
						phase_d = PH_ERROR;
						err_d   = ST_NO_SEMI;
					end
				end
				PH_AFTER_SEMI: begin
					if (cls.is_hash) begin
						phase_d = PH_COMMENT;
					end else if (!cls.is_blank) begin
						phase_d = PH_ERROR;
						err_d   = ST_TRAILING;
					end
				end
				default: begin
					// comment or error: ignore the rest of the line
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			err_q   <= ST_OK;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== src/config_line_syntax_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_line_syntax_checker
// Checks lines of the form  identifier = "argument" ;  # comment
// ----------------------------------------------------------------------------
// Input stream s_*: one word per line character (s_tuser 0) or one
// end-of-line word (s_tuser 1); s_tdata carries the character.
// Output stream m_*: identifier bytes (m_tuser 0) and argument bytes
// (m_tuser 1) as they arrive, and one status word per line (m_tuser 2)
// with the line status in m_tdata[11:8].
// A word that is accepted is held in the input register and parsed, and
// its result is written into the output register, from which it shows
// on m_* until the receiver takes it.
// Throughput: one word per cycle while the receiver does not stall; the
// parser state updates once per accepted word.
// While the receiver stalls, the result waits in the output register and
// the input register still takes one more word; then s_tready drops.
// Words that produce no result also wait behind a stalled result.
// Reset clears the parse state to start of line and empties both
// registers.
// ----------------------------------------------------------------------------
module config_line_syntax_checker import clsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_byte[7:0]
	input  logic [0:0]  s_tuser,   // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte[7:0], line_status[11:8], zero[15:12]
	output logic [1:0]  m_tuser    // out_tag[1:0]
);

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  char_s1;
	logic        out_valid_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [7:0]          out_byte_q;
	logic [STATUS_W-1:0] out_status_q;
	logic        out_free;
	logic        advance;
	char_class_t cls;
	result_t     res;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser[0];
			char_s1 <= s_tdata;
		end
	end

	clsc_char_class u_class (
		.char_byte (char_s1),
		.cls       (cls)
	);

	clsc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.kind      (kind_s1),
		.char_byte (char_s1),
		.cls       (cls),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_tag_q    <= res.tag;
			out_byte_q   <= res.data;
			out_status_q <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_status_q, out_byte_q};
	assign m_tuser  = out_tag_q;

endmodule
